FILE: src/gtc_pkg.sv
package gtc_pkg;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  team;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] radius;
    logic [15:0] lower_limit;
  } in_item_t;

  typedef struct packed {
    logic [23:0] count;
    logic        found;
    logic [5:0]  best_col;
    logic [5:0]  best_row;
  } out_item_t;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_OWN   = 3'd2;
  localparam logic [2:0] OP_ALLY  = 3'd3;
  localparam logic [2:0] OP_ENEMY = 3'd4;
  localparam logic [2:0] OP_PEAK  = 3'd5;
  localparam logic [2:0] OP_BOX   = 3'd6;

  localparam logic [1:0] CFG_COLS = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_CELL = 2'd2;
  localparam logic [1:0] CFG_ALLY = 2'd3;

  localparam logic [1:0] SEL_X0 = 2'd0;
  localparam logic [1:0] SEL_X1 = 2'd1;
  localparam logic [1:0] SEL_Y0 = 2'd2;
  localparam logic [1:0] SEL_Y1 = 2'd3;

  localparam int unsigned DIVD_W = 13;
  localparam logic [3:0] DIV_STEPS = 4'd13;
  localparam logic [23:0] OUT_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic       latch;
    logic       clr_wr;
    logic       div_start;
    logic       div_store;
    logic [1:0] div_sel;
    logic       cell_init;
    logic       mem_rd;
    logic       calc_prod;
    logic       calc_diff;
    logic       calc_sq;
    logic       calc_hit;
    logic       accum;
    logic       step;
    logic       add_wr;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       team_ok;
    logic       div_done;
    logic       cell_last;
    logic       clr_last;
  } dp_sts_t;

endpackage

FILE: src/grid_team_count_radius_query_top.sv
// Add and box count both start with four cell-index divisions, as do radius queries,
// which then visit each cell of the covering rectangle; clear sweeps the whole store
// and an unused op goes straight to its result, which waits while a prior one stalls.
// One item in flight; the next is taken the cycle after its result is loaded, even
// while that result waits. Reset is synchronous: after it all MAX_COLS*MAX_ROWS cells
// of the store (4096 by default) are swept to zero with in_stall high; config writes taken.
module grid_team_count_radius_query_top import gtc_pkg::*; #(
  parameter int MAX_COLS   = 64,
  parameter int MAX_ROWS   = 64,
  parameter int TEAMS      = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  gtc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_item.op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gtc_dp #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .TEAMS      (TEAMS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .out_item  (out_item),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

FILE: src/gtc_div.sv
module gtc_div import gtc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [10:0]       divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  logic [DIVD_W-1:0] quo_r;
  logic [10:0]       rem_r;
  logic [10:0]       div_r;
  logic [3:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [11:0]       trial;
  logic [11:0]       diff;
  logic              ge;

  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= diff[10:0];
        quo_r <= {quo_r[DIVD_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[10:0];
        quo_r <= {quo_r[DIVD_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: src/gtc_dp.sv
module gtc_dp import gtc_pkg::*; #(
  parameter int MAX_COLS   = 64,
  parameter int MAX_ROWS   = 64,
  parameter int TEAMS      = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  in_item_t    in_item,
  output out_item_t   out_item,
  input  logic        cfg_wr,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int LW    = TEAMS * COUNT_BITS;
  localparam int SW    = COUNT_BITS + 3;
  localparam int BW    = (SW + 1 > 17) ? SW + 1 : 17;
  localparam int TW    = (SW > 24) ? SW + 1 : 25;
  localparam logic [8:0] MAXC9 = 9'(MAX_COLS);
  localparam logic [8:0] MAXR9 = 9'(MAX_ROWS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

  logic [6:0]  grid_cols_r;
  logic [6:0]  grid_rows_r;
  logic [10:0] cell_size_r;
  logic [63:0] ally_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= 7'd64;
      grid_rows_r <= 7'd64;
      cell_size_r <= 11'd32;
      ally_r      <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_COLS: grid_cols_r <= cfg_data[6:0];
        CFG_ROWS: grid_rows_r <= cfg_data[6:0];
        CFG_CELL: cell_size_r <= cfg_data[10:0];
        CFG_ALLY: ally_r      <= cfg_data;
        default:  ally_r      <= ally_r;
      endcase
    end
  end

  logic [8:0]  cols_used;
  logic [8:0]  rows_used;
  logic [10:0] cs_used;

  always_comb begin
    cols_used = {2'b0, grid_cols_r};
    if (cols_used == 9'd0) cols_used = 9'd1;
    else if (cols_used > MAXC9) cols_used = MAXC9;
    rows_used = {2'b0, grid_rows_r};
    if (rows_used == 9'd0) rows_used = 9'd1;
    else if (rows_used > MAXR9) rows_used = MAXR9;
    cs_used = (cell_size_r == 11'd0) ? 11'd1 : cell_size_r;
  end

  logic [2:0]  op_r;
  logic [3:0]  team_r;
  logic [15:0] px_r;
  logic [15:0] py_r;
  logic [15:0] rad_r;
  logic [15:0] lim_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_item.op;
      team_r <= in_item.team;
      px_r   <= in_item.pos_x;
      py_r   <= in_item.pos_y;
      lim_r  <= in_item.lower_limit;
      if (in_item.op >= OP_OWN && in_item.op <= OP_PEAK) rad_r <= in_item.radius;
      else rad_r <= '0;
    end
  end

  logic       team_ok;
  logic [3:0] team_m1;
  assign team_ok = (team_r >= 4'd1) && ({28'd0, team_r} <= 32'(TEAMS));
  assign team_m1 = team_r - 4'd1;

  logic [16:0]       dvd_val;
  logic              div_done;
  logic [DIVD_W-1:0] quo;

  always_comb begin
    unique case (cmd.div_sel)
      SEL_X0:  dvd_val = (px_r > rad_r) ? {1'b0, px_r - rad_r} : 17'd0;
      SEL_X1:  dvd_val = {1'b0, px_r} + {1'b0, rad_r};
      SEL_Y0:  dvd_val = (py_r > rad_r) ? {1'b0, py_r - rad_r} : 17'd0;
      default: dvd_val = {1'b0, py_r} + {1'b0, rad_r};
    endcase
  end

  gtc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd_val[16:4]),
    .divisor  (cs_used),
    .done     (div_done),
    .quotient (quo)
  );

  logic [8:0] lim_m1;
  logic [8:0] q_clamp;
  always_comb begin
    lim_m1 = (cmd.div_sel == SEL_X0 || cmd.div_sel == SEL_X1) ?
             cols_used - 9'd1 : rows_used - 9'd1;
    q_clamp = (quo > {4'd0, lim_m1}) ? lim_m1 : quo[8:0];
  end

  logic [CW-1:0] x0_r, x1_r, x_r;
  logic [RW-1:0] y0_r, y1_r, y_r;

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      unique case (cmd.div_sel)
        SEL_X0:  x0_r <= q_clamp[CW-1:0];
        SEL_X1:  x1_r <= q_clamp[CW-1:0];
        SEL_Y0:  y0_r <= q_clamp[RW-1:0];
        default: y1_r <= q_clamp[RW-1:0];
      endcase
    end
    if (cmd.cell_init) begin
      x_r <= x0_r;
      y_r <= y0_r;
    end else if (cmd.step) begin
      if (y_r == y1_r) begin
        y_r <= y0_r;
        x_r <= x_r + 1'b1;
      end else begin
        y_r <= y_r + 1'b1;
      end
    end
  end

  logic [LW-1:0] mem [CELLS];
  logic [LW-1:0] rd_data_r;
  logic [AW-1:0] cell_addr;
  logic [AW-1:0] clr_cnt_r;
  logic [LW-1:0] add_row;

  assign cell_addr = AW'(y_r) * AW'(MAX_COLS) + AW'(x_r);

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.latch) clr_cnt_r <= '0;
    else if (cmd.clr_wr) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) mem[clr_cnt_r] <= '0;
    else if (cmd.add_wr) mem[cell_addr] <= add_row;
    if (cmd.mem_rd) rd_data_r <= mem[cell_addr];
  end

  logic [TEAMS-1:0]      mask;
  logic [SW-1:0]         sum_c;
  logic [COUNT_BITS-1:0] lane;

  always_comb begin
    add_row = rd_data_r;
    sum_c   = '0;
    for (int i = 0; i < TEAMS; i++) begin
      lane = rd_data_r[i*COUNT_BITS +: COUNT_BITS];
      unique case (op_r)
        OP_OWN, OP_BOX: mask[i] = team_ok && (team_m1 == 4'(i));
        OP_ALLY:        mask[i] = team_ok && ally_r[{team_m1[2:0], 3'(i)}];
        default:        mask[i] = !(team_ok && ally_r[{team_m1[2:0], 3'(i)}]);
      endcase
      if (mask[i]) sum_c = sum_c + SW'(lane);
      if (team_ok && (team_m1 == 4'(i)) && (lane != '1))
        add_row[i*COUNT_BITS +: COUNT_BITS] = lane + 1'b1;
    end
  end

  logic [22:0] xp_r, yp_r;
  logic [22:0] dx_r, dy_r;
  logic [45:0] dx2_r, dy2_r;
  logic [33:0] tr2_r;
  logic [16:0] tr;
  logic [23:0] dxs, dys;
  logic        hit_r;
  logic [SW-1:0] sum_r;

  assign tr  = {1'b0, rad_r} + {2'b0, cs_used[10:1], 4'b0};
  assign dxs = {1'b0, xp_r[18:0], 4'b0} - {8'd0, px_r};
  assign dys = {1'b0, yp_r[18:0], 4'b0} - {8'd0, py_r};

  always_ff @(posedge clk) begin
    tr2_r <= {17'd0, tr} * {17'd0, tr};
    if (cmd.calc_prod) begin
      xp_r <= 23'(x_r) * 23'(cs_used);
      yp_r <= 23'(y_r) * 23'(cs_used);
    end
    if (cmd.calc_diff) begin
      dx_r <= dxs[23] ? 23'(-dxs) : dxs[22:0];
      dy_r <= dys[23] ? 23'(-dys) : dys[22:0];
    end
    if (cmd.calc_sq) begin
      dx2_r <= {23'd0, dx_r} * {23'd0, dy_r & 23'd0 | dx_r};
      dy2_r <= {23'd0, dy_r} * {23'd0, dy_r};
      sum_r <= sum_c;
    end
    if (cmd.calc_hit)
      hit_r <= (op_r == OP_BOX) ||
               (({1'b0, dx2_r} + {1'b0, dy2_r}) < {13'd0, tr2_r});
  end

  logic [23:0]   total_r;
  logic          found_r;
  logic [CW-1:0] bcol_r;
  logic [RW-1:0] brow_r;
  logic [BW-1:0] best_r;
  logic [TW-1:0] acc_w;
  logic [23:0]   sum_sat;
  logic [23:0]   acc_sat;

  assign acc_w   = TW'(total_r) + TW'(sum_r);
  assign acc_sat = (acc_w > TW'(OUT_MAX)) ? OUT_MAX : acc_w[23:0];
  assign sum_sat = (TW'(sum_r) > TW'(OUT_MAX)) ? OUT_MAX : 24'(sum_r);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      total_r <= '0;
      found_r <= 1'b0;
      bcol_r  <= '0;
      brow_r  <= '0;
      best_r  <= BW'(in_item.lower_limit);
    end else if (cmd.accum && hit_r) begin
      if (op_r == OP_PEAK) begin
        if (lim_r != 16'd0 && BW'(sum_r) >= best_r) begin
          best_r  <= BW'(sum_r) + 1'b1;
          found_r <= 1'b1;
          bcol_r  <= x_r;
          brow_r  <= y_r;
          total_r <= sum_sat;
        end
      end else begin
        total_r <= acc_sat;
      end
    end
  end

  out_item_t out_r;
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.count    <= total_r;
      out_r.found    <= found_r;
      out_r.best_col <= 6'(bcol_r);
      out_r.best_row <= 6'(brow_r);
    end
  end
  assign out_item = out_r;

  assign sts.op        = op_r;
  assign sts.team_ok   = team_ok;
  assign sts.div_done  = div_done;
  assign sts.cell_last = (x_r == x1_r) && (y_r == y1_r);
  assign sts.clr_last  = (clr_cnt_r == LAST_ADDR);

endmodule

FILE: src/gtc_ctrl.sv
module gtc_ctrl import gtc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic [2:0] in_op,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_sts_t  sts,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR, S_DIVGO, S_DIVW, S_PREP,
    S_C1, S_C2, S_C3, S_C4, S_C5, S_ADDW, S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.div_sel   = sel_r;
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_INIT: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          sel_nxt   = SEL_X0;
          if (in_op == OP_CLEAR) state_nxt = S_CLR;
          else if (in_op > OP_BOX) state_nxt = S_DONE;
          else state_nxt = S_DIVGO;
        end
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_DONE;
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          sel_nxt       = sel_r + 2'd1;
          state_nxt     = (sel_r == SEL_Y1) ? S_PREP : S_DIVGO;
        end
      end
      S_PREP: begin
        cmd.cell_init = 1'b1;
        state_nxt     = S_C1;
      end
      S_C1: begin
        cmd.mem_rd    = 1'b1;
        cmd.calc_prod = 1'b1;
        state_nxt     = (sts.op == OP_ADD) ? S_ADDW : S_C2;
      end
      S_ADDW: begin
        cmd.add_wr = sts.team_ok;
        state_nxt  = S_DONE;
      end
      S_C2: begin
        cmd.calc_diff = 1'b1;
        state_nxt     = S_C3;
      end
      S_C3: begin
        cmd.calc_sq = 1'b1;
        state_nxt   = S_C4;
      end
      S_C4: begin
        cmd.calc_hit = 1'b1;
        state_nxt    = S_C5;
      end
      S_C5: begin
        cmd.accum = 1'b1;
        if (sts.cell_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_C1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sel_r       <= SEL_X0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: bench/grid_team_count_radius_query_top_tb.sv
module grid_team_count_radius_query_top_tb;
  import gtc_pkg::*;

  localparam int GCOLS = 64;
  localparam int GROWS = 64;
  localparam int NTEAMS = 8;
  localparam int CMAX = 65535;
  localparam longint CYCLE_LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_COLS;
  logic [63:0] cfg_data = '0;

  grid_team_count_radius_query_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the grid state
  logic [15:0] unit_tally [0:GCOLS*GROWS*NTEAMS-1];
  logic [6:0]  m_cols;
  logic [6:0]  m_rows;
  logic [10:0] m_cell;
  logic [63:0] m_ally;

  in_item_t  order_queue[$];
  out_item_t pending_answers[$];
  int        mismatches = 0;
  longint    cycles = 0;
  bit        live = 0;

  task automatic enqueue(input in_item_t it);
    order_queue = {order_queue, it};
  endtask

  function automatic int unsigned cols_eff();
    return (m_cols == 0) ? 1 : ((m_cols > GCOLS) ? GCOLS : m_cols);
  endfunction

  function automatic int unsigned rows_eff();
    return (m_rows == 0) ? 1 : ((m_rows > GROWS) ? GROWS : m_rows);
  endfunction

  function automatic int unsigned cell_eff();
    return (m_cell == 0) ? 1 : m_cell;
  endfunction

  function automatic int unsigned cell_index(int unsigned q4, int unsigned lim);
    int unsigned c;
    c = (q4 >> 4) / cell_eff();
    return (c > lim - 1) ? lim - 1 : c;
  endfunction

  function automatic bit team_ok(int unsigned t);
    return t >= 1 && t <= NTEAMS;
  endfunction

  function automatic bit allied(int unsigned a, int unsigned b);
    if (!team_ok(a) || !team_ok(b)) return 1'b0;
    return m_ally[(a - 1) * 8 + (b - 1)];
  endfunction

  function automatic int unsigned slot_of(int unsigned c, int unsigned r, int unsigned t);
    return (r * GCOLS + c) * NTEAMS + t;
  endfunction

  function automatic longint unsigned team_sum(int unsigned c, int unsigned r,
                                               int unsigned t, logic [2:0] op);
    longint unsigned s;
    bit take;
    s = 0;
    for (int i = 0; i < NTEAMS; i++) begin
      if (op == OP_OWN) take = team_ok(t) && (i + 1 == t);
      else if (op == OP_ALLY) take = allied(t, i + 1);
      else take = !allied(t, i + 1);
      if (take) s += unit_tally[slot_of(c, r, i)];
    end
    return s;
  endfunction

  function automatic out_item_t grid_answer(in_item_t it);
    out_item_t res;
    longint unsigned total, best, tr2, s, d2;
    longint dx, dy;
    int unsigned cs, px, py, rad, x0, x1, y0, y1, k;
    res = '0;
    total = 0;
    cs = cell_eff();
    px = it.pos_x;
    py = it.pos_y;
    rad = it.radius;
    case (it.op)
      OP_CLEAR: begin
        for (int i = 0; i < GCOLS*GROWS*NTEAMS; i++) unit_tally[i] = '0;
      end
      OP_ADD: begin
        if (team_ok(it.team)) begin
          k = slot_of(cell_index(px, cols_eff()), cell_index(py, rows_eff()), it.team - 1);
          if (unit_tally[k] < CMAX) unit_tally[k] = unit_tally[k] + 16'd1;
        end
      end
      OP_BOX: begin
        if (team_ok(it.team))
          total = unit_tally[slot_of(cell_index(px, cols_eff()), cell_index(py, rows_eff()),
                                     it.team - 1)];
      end
      OP_OWN, OP_ALLY, OP_ENEMY, OP_PEAK: begin
        x0 = cell_index(px > rad ? px - rad : 0, cols_eff());
        x1 = cell_index(px + rad, cols_eff());
        y0 = cell_index(py > rad ? py - rad : 0, rows_eff());
        y1 = cell_index(py + rad, rows_eff());
        tr2 = longint'(rad) + (longint'(cs / 2) << 4);
        tr2 = tr2 * tr2;
        best = it.lower_limit;
        for (int unsigned x = x0; x <= x1; x++) begin
          for (int unsigned y = y0; y <= y1; y++) begin
            dx = longint'(x * cs * 16) - longint'(px);
            dy = longint'(y * cs * 16) - longint'(py);
            d2 = dx * dx + dy * dy;
            if (d2 < tr2) begin
              if (it.op == OP_PEAK) begin
                s = team_sum(x, y, it.team, OP_ENEMY);
                if (it.lower_limit != 0 && s >= best) begin
                  best = s + 1;
                  res.found = 1'b1;
                  res.best_col = x[5:0];
                  res.best_row = y[5:0];
                  total = s;
                end
              end else begin
                total += team_sum(x, y, it.team, it.op);
              end
            end
          end
        end
      end
      default: ;
    endcase
    res.count = (total > OUT_MAX) ? OUT_MAX : total[23:0];
    return res;
  endfunction

  // sender: bursts and gaps
  in_item_t cur_item = '0;
  int burst_left = 4;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      live = 0;
      in_valid <= 1'b0;
    end else begin
      if (live && !in_stall) begin
        pending_answers = {pending_answers, grid_answer(cur_item)};
        live = 0;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
        end
      end
      if (!live) begin
        if (gap_left > 0) gap_left--;
        else if (order_queue.size() > 0) begin
          cur_item = order_queue.pop_front();
          live = 1;
        end
      end
      in_valid <= live;
      in_item <= cur_item;
    end
  end

  // receiver: checks each result; the stall pattern steps through four modes
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item);
      end else begin
        want = pending_answers.pop_front();
        if (want.count !== out_item.count || want.found !== out_item.found ||
            want.best_col !== out_item.best_col || want.best_row !== out_item.best_row) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp count=%0d found=%0d col=%0d row=%0d, got %0d %0d %0d %0d",
                     want.count, want.found, want.best_col, want.best_row,
                     out_item.count, out_item.found, out_item.best_col, out_item.best_row);
        end
      end
    end
    case (cycles[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= cycles[4];
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_COLS: m_cols = val[6:0];
      CFG_ROWS: m_rows = val[6:0];
      CFG_CELL: m_cell = val[10:0];
      default:  m_ally = val;
    endcase
  endtask

  task automatic drain();
    while (order_queue.size() != 0 || live || pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic in_item_t mk(logic [2:0] op, logic [3:0] team, logic [15:0] x,
                                  logic [15:0] y, logic [15:0] r, logic [15:0] lim);
    in_item_t it;
    it.op = op; it.team = team; it.pos_x = x; it.pos_y = y;
    it.radius = r; it.lower_limit = lim;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned pick, span;
    logic [15:0] hx [4];
    logic [15:0] hy [4];
    span = cell_eff() * 16;
    hx = '{16'd0, 16'd300, 16'd2000, 16'd65535};
    hy = '{16'd0, 16'd700, 16'd1500, 16'd65535};
    it = '0;
    pick = $urandom_range(0, 199);
    if (pick < 2) it.op = OP_CLEAR;
    else if (pick < 6) it.op = 3'd7;
    else if (pick < 86) it.op = OP_ADD;
    else if (pick < 106) it.op = OP_BOX;
    else if (pick < 126) it.op = OP_OWN;
    else if (pick < 146) it.op = OP_ALLY;
    else if (pick < 166) it.op = OP_ENEMY;
    else it.op = OP_PEAK;
    it.team = 4'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8));
    if ($urandom_range(0, 2) == 0) begin
      it.pos_x = 16'($urandom);
      it.pos_y = 16'($urandom);
    end else begin
      pick = $urandom_range(0, 3);
      it.pos_x = 16'(hx[pick] + ((pick == 3) ? -$urandom_range(0, span)
                                              : $urandom_range(0, span)));
      it.pos_y = 16'(hy[pick] + ((pick == 3) ? -$urandom_range(0, span)
                                              : $urandom_range(0, span)));
    end
    pick = $urandom_range(0, 99);
    if (pick < 2) it.radius = 16'($urandom);
    else if (pick < 6) it.radius = 16'd0;
    else it.radius = 16'((span * 3 > 65535) ? $urandom : $urandom_range(0, span * 3));
    pick = $urandom_range(0, 9);
    if (pick < 5) it.lower_limit = 16'($urandom_range(0, 4));
    else if (pick < 7) it.lower_limit = 16'($urandom_range(1, 30));
    else it.lower_limit = 16'($urandom);
    return it;
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) enqueue(random_item());
    drain();
  endtask

  initial begin
    for (int i = 0; i < GCOLS*GROWS*NTEAMS; i++) unit_tally[i] = '0;
    m_cols = 7'd64;
    m_rows = 7'd64;
    m_cell = 11'd32;
    m_ally = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_ALLY, 64'h8142_2418_1824_4281);
    enqueue(mk(3'd7, 4'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    enqueue(mk(OP_ADD, 4'd1, 16'd0, 16'd0, 16'd0, 16'd0));
    enqueue(mk(OP_ADD, 4'd8, 16'd0, 16'd0, 16'd0, 16'd0));
    enqueue(mk(OP_ADD, 4'd8, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0));
    enqueue(mk(OP_ADD, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    enqueue(mk(OP_ADD, 4'd9, 16'd0, 16'd0, 16'd0, 16'd0));
    enqueue(mk(OP_ADD, 4'd15, 16'd600, 16'd40, 16'd0, 16'd0));
    enqueue(mk(OP_ADD, 4'd2, 16'd600, 16'd40, 16'd0, 16'd0));
    enqueue(mk(OP_BOX, 4'd8, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0));
    enqueue(mk(OP_BOX, 4'd1, 16'd5, 16'd5, 16'd0, 16'd0));
    enqueue(mk(OP_BOX, 4'd0, 16'd5, 16'd5, 16'd0, 16'd0));
    enqueue(mk(OP_OWN, 4'd8, 16'd0, 16'd0, 16'd0, 16'd0));
    enqueue(mk(OP_OWN, 4'd12, 16'd0, 16'd0, 16'd600, 16'd0));
    enqueue(mk(OP_ALLY, 4'd1, 16'd10, 16'd10, 16'd800, 16'd0));
    enqueue(mk(OP_ALLY, 4'd0, 16'd10, 16'd10, 16'd800, 16'd0));
    enqueue(mk(OP_ENEMY, 4'd1, 16'd10, 16'd10, 16'd800, 16'd0));
    enqueue(mk(OP_ENEMY, 4'd14, 16'hFFFF, 16'hFFFF, 16'd1000, 16'd0));
    enqueue(mk(OP_PEAK, 4'd3, 16'd100, 16'd100, 16'd1200, 16'd0));
    enqueue(mk(OP_PEAK, 4'd3, 16'd100, 16'd100, 16'd1200, 16'd1));
    enqueue(mk(OP_PEAK, 4'd0, 16'd100, 16'd100, 16'd1200, 16'd2));
    enqueue(mk(OP_PEAK, 4'd3, 16'd100, 16'd100, 16'd1200, 16'hFFFF));
    enqueue(mk(OP_ENEMY, 4'd5, 16'h8000, 16'h8000, 16'hFFFF, 16'd0));
    enqueue(mk(OP_CLEAR, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    enqueue(mk(OP_BOX, 4'd8, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0));
    drain();
    random_run(300);

    write_reg(CFG_COLS, 64'd5);
    write_reg(CFG_ROWS, 64'd3);
    write_reg(CFG_CELL, 64'd1);
    write_reg(CFG_ALLY, {$urandom, $urandom});
    random_run(200);

    write_reg(CFG_COLS, 64'd0);
    write_reg(CFG_ROWS, 64'd127);
    write_reg(CFG_CELL, 64'd0);
    write_reg(CFG_ALLY, '1);
    random_run(150);

    write_reg(CFG_COLS, 64'd64);
    write_reg(CFG_ROWS, 64'd64);
    write_reg(CFG_CELL, 64'd2047);
    write_reg(CFG_ALLY, {$urandom, $urandom});
    random_run(150);

    write_reg(CFG_COLS, 64'd1);
    write_reg(CFG_ROWS, 64'd1);
    write_reg(CFG_CELL, 64'd1024);
    random_run(100);

    write_reg(CFG_COLS, 64'd17);
    write_reg(CFG_ROWS, 64'd40);
    write_reg(CFG_CELL, 64'd7);
    write_reg(CFG_ALLY, 64'd0);
    random_run(250);

    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
